// ===== sv/tspm_pkg.sv =====
package tspm_pkg;

  // Field widths: Q16.16 coordinates, Q15.16 speeds, Q32.16 times
  localparam int CW  = 32;
  localparam int SW  = 31;
  localparam int TW  = 48;
  localparam int FB  = 16;
  localparam int TKW = 32;

  // Shared unit widths: 64-bit divide, 48 x 32 multiply
  localparam int AW  = 64;
  localparam int MA  = 48;
  localparam int MB  = 32;
  localparam int PW  = MA + MB;

  // Configuration port index width
  localparam int CFG_IW = 3;

  // Tick search bound and its counter width
  localparam int SRCH_LIMIT = 65536;
  localparam int NW         = 17;

  // Speed cut: cover the distance in this many ticks
  localparam int CUT_TICKS = 10;

  typedef enum logic [1:0] {
    OP_PLAN   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_STOP   = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_SLOW   = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MIN_COORD   = 3'd0,
    CFG_MAX_COORD   = 3'd1,
    CFG_MIN_SPEED   = 3'd2,
    CFG_MAX_SPEED   = 3'd3,
    CFG_TOLERANCE   = 3'd4,
    CFG_TICK_LENGTH = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic          start;
    alu_op_t       op;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic          busy;
    logic [PW-1:0] prod;
    logic [AW-1:0] quo;
    logic [AW-1:0] rem;
  } alu_rsp_t;

endpackage

// ===== sv/tspm_in_if.sv =====
interface tspm_in_if;
  import tspm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic signed [CW-1:0] target_coord;
  logic [SW-1:0]        target_speed;
  logic [TW-1:0]        now;

  modport source (output valid, output opcode, output target_coord,
                  output target_speed, output now, input ready);
  modport sink   (input valid, input opcode, input target_coord,
                  input target_speed, input now, output ready);
endinterface

// ===== sv/tspm_out_if.sv =====
interface tspm_out_if;
  import tspm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 status;
  logic                 moving;
  logic [1:0]           phase;
  logic signed [CW-1:0] position;
  logic signed [CW-1:0] velocity;

  modport source (output valid, output status, output moving, output phase,
                  output position, output velocity, input ready);
  modport sink   (input valid, input status, input moving, input phase,
                  input position, input velocity, output ready);
endinterface

// ===== sv/tspm_alu.sv =====
module tspm_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  tspm_pkg::alu_req_t  req,
  output tspm_pkg::alu_rsp_t  rsp
);
  import tspm_pkg::*;

  localparam int CNTW = $clog2(AW);
  localparam logic [CNTW-1:0] MUL_LAST = CNTW'(MB - 1);
  localparam logic [CNTW-1:0] DIV_LAST = CNTW'(AW - 1);

  logic            busy_r;
  logic            done_r;
  alu_op_t         op_r;
  logic [CNTW-1:0] cnt_r;
  logic [AW-1:0]   a_r;
  logic [AW-1:0]   b_r;
  logic [AW-1:0]   hi_r;
  logic [AW-1:0]   lo_r;

  logic [MA:0]     mul_sum;
  logic [AW:0]     div_sh;
  logic [AW:0]     div_diff;
  logic            div_ge;

  // Shift-add multiply step: add multiplicand on low bit, shift right
  assign mul_sum = {1'b0, hi_r[MA-1:0]} + (lo_r[0] ? {1'b0, a_r[MA-1:0]} : '0);

  // Restoring divide step: shift in next dividend bit, subtract if it fits
  assign div_sh   = {hi_r, lo_r[AW-1]};
  assign div_ge   = div_sh >= {1'b0, b_r};
  assign div_diff = div_sh - {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      // Pulse done after the last step
      done_r <= busy_r && (cnt_r == '0);
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        a_r    <= req.a;
        b_r    <= req.b;
        hi_r   <= '0;
        if (req.op == ALU_MUL) begin
          lo_r  <= {{(AW-MB){1'b0}}, req.b[MB-1:0]};
          cnt_r <= MUL_LAST;
        end else begin
          lo_r  <= req.a;
          cnt_r <= DIV_LAST;
        end
      end else if (busy_r) begin
        if (op_r == ALU_MUL) begin
          hi_r <= {{(AW-MA){1'b0}}, mul_sum[MA:1]};
          lo_r <= {{(AW-MB){1'b0}}, mul_sum[0], lo_r[MB-1:1]};
        end else begin
          hi_r <= div_ge ? div_diff[AW-1:0] : div_sh[AW-1:0];
          lo_r <= {lo_r[AW-2:0], div_ge};
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.prod = {hi_r[MA-1:0], lo_r[MB-1:0]};
  assign rsp.quo  = lo_r;
  assign rsp.rem  = hi_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("alu started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("alu done without work");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("alu done longer than one cycle");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && op_r == ALU_DIV && b_r != '0 |-> hi_r < b_r)
    else $error("alu remainder not below divisor");

endmodule

// ===== sv/two_speed_position_mover_unit.sv =====
// Constant-speed position mover with a slow final phase. Each transfer on
// in_ch carries one command (plan move, time update, stop, read state) and
// yields exactly one result on out_ch with the status and the state after
// the command. in_ch is ready only while the sequencer is idle. A time
// update uses one 32-step shift-add multiply. A plan move runs its
// multiplies and 64-step divides in the shared arithmetic unit, plus a
// switch-tick search over up to 65536 candidates, one candidate per
// cycle. The configuration port takes a write on any cycle where cfg_we
// is high.
module two_speed_position_mover_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  tspm_in_if.sink                         in_ch,
  tspm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tspm_pkg::CFG_IW-1:0]     cfg_idx,
  input  logic [tspm_pkg::CW-1:0]         cfg_wdata
);
  import tspm_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_DISPATCH = 15'b000000000000010,
    ST_MS       = 15'b000000000000100,
    ST_TS       = 15'b000000000001000,
    ST_CUT      = 15'b000000000010000,
    ST_SPD      = 15'b000000000100000,
    ST_D        = 15'b000000001000000,
    ST_K        = 15'b000000010000000,
    ST_DM       = 15'b000000100000000,
    ST_R0       = 15'b000001000000000,
    ST_SRCH     = 15'b000010000000000,
    ST_SWT      = 15'b000100000000000,
    ST_COMMIT   = 15'b001000000000000,
    ST_ADV      = 15'b010000000000000,
    ST_RESP     = 15'b100000000000000
  } state_t;

  localparam logic [NW-1:0] LIMIT_N = NW'(SRCH_LIMIT);
  localparam logic signed [CW+1:0] CMAX_W = 34'sh0_7FFF_FFFF;
  localparam logic signed [CW+1:0] CMIN_W = -34'sh0_8000_0000;

  state_t state_r;

  // Configuration
  logic signed [CW-1:0] min_coord_r, max_coord_r;
  logic [SW-1:0]        min_speed_r, max_speed_r, tol_r;
  logic [TKW-1:0]       tick_r;

  // Mover state
  logic                 run_r, seg_valid_r, sw_valid_r;
  phase_t               phase_r;
  logic [TW-1:0]        seg_time_r, sw_time_r;
  logic signed [CW-1:0] seg_coord_r, goal_r, cur_coord_r, cur_speed_r;

  // Latched command
  opcode_t              op_r;
  logic signed [CW-1:0] tgt_r;
  logic [SW-1:0]        ts_r;
  logic [TW-1:0]        now_r;

  // Plan work registers
  logic [AW-1:0]        s_r, d_r, dm_r, srch_r;
  logic [SW-1:0]        spd_r;
  logic [MA-1:0]        k_r;
  logic [NW-1:0]        n_r;
  logic [TW-1:0]        swt_r;
  logic                 sw_r, dneg_r, status_r;

  // Result register
  logic                 out_valid_r, out_status_r, out_moving_r;
  logic [1:0]           out_phase_r;
  logic signed [CW-1:0] out_pos_r, out_vel_r;

  alu_req_t alu_req_r;
  alu_rsp_t alu_rsp;

  tspm_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req_r),
    .rsp   (alu_rsp)
  );

  // Plan operands
  logic [TKW-1:0]       tk;
  logic signed [CW:0]   diff;
  logic [CW-1:0]        adist;
  logic [TW-1:0]        adq;
  logic [AW-1:0]        adq_w;
  logic [AW-1:0]        tolq;
  logic                 range_bad;
  logic [TKW+3:0]       tenk;
  logic [AW-1:0]        srch_add, srch_nxt;
  logic                 srch_on, srch_hit;
  logic [MA-1:0]        k_fin;
  logic [TW:0]          swt_sum;
  logic [TW-1:0]        swt;
  logic signed [CW-1:0] plan_vel;

  assign tk    = (tick_r == '0) ? TKW'(1) : tick_r;
  assign diff  = {tgt_r[CW-1], tgt_r} - {cur_coord_r[CW-1], cur_coord_r};
  assign adist = diff[CW] ? CW'(-diff) : diff[CW-1:0];
  assign adq   = {adist, {FB{1'b0}}};
  assign adq_w = {{(AW-TW){1'b0}}, adq};
  assign tolq  = {{(AW-SW-FB){1'b0}}, tol_r, {FB{1'b0}}};
  assign range_bad = (ts_r > max_speed_r) || (ts_r < min_speed_r) ||
                     (tgt_r < min_coord_r) || (tgt_r > max_coord_r);
  assign tenk  = ({4'b0, tk} << 3) + ({4'b0, tk} << 1);

  // Remainder of the next candidate, kept modulo one slow tick
  assign srch_add = srch_r + dm_r;
  assign srch_nxt = (srch_add >= s_r) ? srch_add - s_r : srch_add;
  assign srch_on  = (k_r > MA'(1)) && (n_r < LIMIT_N);
  assign srch_hit = srch_r < tolq;
  assign k_fin    = (!srch_on && n_r >= LIMIT_N) ? MA'(1) : k_r;

  // Switch time saturates when the tick product or the sum leaves the range
  assign swt_sum = {1'b0, now_r} + {1'b0, alu_rsp.prod[TW-1:0]};
  assign swt     = (swt_sum[TW] || (alu_rsp.prod[PW-1:TW] != '0)) ? {TW{1'b1}}
                                                                  : swt_sum[TW-1:0];
  assign plan_vel = (tgt_r < cur_coord_r) ? -$signed({1'b0, spd_r})
                                          : $signed({1'b0, spd_r});

  // Time update operands and result
  logic [TW-1:0]        mdt;
  logic [MB-1:0]        msp;
  logic                 sneg;
  logic [CW:0]          mag;
  logic signed [CW+1:0] pos_w;
  logic signed [CW-1:0] pos_sat;
  logic                 over, sw_hit, near;
  logic signed [CW:0]   err;
  logic [CW-1:0]        aerr;
  logic signed [CW-1:0] slow_vel;

  assign mdt  = (now_r < seg_time_r) ? seg_time_r - now_r : now_r - seg_time_r;
  assign sneg = cur_speed_r[CW-1];
  assign msp  = sneg ? MB'(-cur_speed_r) : MB'(cur_speed_r);
  assign mag  = (alu_rsp.prod[PW-1:TW] != '0) ? {1'b1, {CW{1'b0}}}
                                                : {1'b0, alu_rsp.prod[TW-1:FB]};
  assign pos_w = (dneg_r != sneg)
               ? $signed({{2{seg_coord_r[CW-1]}}, seg_coord_r}) - $signed({1'b0, mag})
               : $signed({{2{seg_coord_r[CW-1]}}, seg_coord_r}) + $signed({1'b0, mag});
  assign pos_sat = (pos_w > CMAX_W) ? CW'(CMAX_W) :
                   (pos_w < CMIN_W) ? CW'(CMIN_W) : pos_w[CW-1:0];
  assign over   = sneg ? (pos_sat < goal_r) : (pos_sat > goal_r);
  assign sw_hit = (phase_r == PH_NORMAL) && sw_valid_r && (now_r >= sw_time_r);
  assign err    = {pos_sat[CW-1], pos_sat} - {goal_r[CW-1], goal_r};
  assign aerr   = err[CW] ? CW'(-err) : err[CW-1:0];
  assign near   = aerr < {1'b0, tol_r};
  assign slow_vel = (cur_speed_r > 0) ? $signed({1'b0, min_speed_r})
                                      : -$signed({1'b0, min_speed_r});

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      min_coord_r  <= -32'sh8000_0000;
      max_coord_r  <= 32'sh7FFF_FFFF;
      min_speed_r  <= 31'd65536;
      max_speed_r  <= 31'h7FFF_FFFF;
      tol_r        <= 31'd65;
      tick_r       <= 32'd655;
      run_r        <= 1'b0;
      phase_r      <= PH_STOP;
      seg_valid_r  <= 1'b0;
      seg_time_r   <= '0;
      seg_coord_r  <= '0;
      sw_valid_r   <= 1'b0;
      sw_time_r    <= '0;
      goal_r       <= '0;
      cur_coord_r  <= '0;
      cur_speed_r  <= '0;
      out_valid_r  <= 1'b0;
      alu_req_r    <= '0;
      op_r         <= OP_READ;
      status_r     <= 1'b0;
    end else begin
      // Drop the start request in the cycle after it was issued
      if (alu_req_r.start) alu_req_r.start <= 1'b0;

      // Write configuration
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIN_COORD:   min_coord_r <= cfg_wdata;
          CFG_MAX_COORD:   max_coord_r <= cfg_wdata;
          CFG_MIN_SPEED:   min_speed_r <= cfg_wdata[SW-1:0];
          CFG_MAX_SPEED:   max_speed_r <= cfg_wdata[SW-1:0];
          CFG_TOLERANCE:   tol_r       <= cfg_wdata[SW-1:0];
          CFG_TICK_LENGTH: tick_r      <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop result once transferred, unless a new one replaces it
      if (out_valid_r && out_ch.ready && state_r != ST_RESP) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            op_r     <= opcode_t'(in_ch.opcode);
            tgt_r    <= in_ch.target_coord;
            ts_r     <= in_ch.target_speed;
            now_r    <= in_ch.now;
            status_r <= 1'b0;
            state_r  <= ST_DISPATCH;
          end
        end

        ST_DISPATCH: begin
          case (op_r)
            OP_PLAN: begin
              if (range_bad) begin
                status_r <= 1'b1;
                state_r  <= ST_RESP;
              end else if (adist < {1'b0, tol_r}) begin
                state_r <= ST_RESP;
              end else begin
                alu_req_r <= '{start: 1'b1, op: ALU_MUL,
                               a: AW'(min_speed_r), b: AW'(tk)};
                state_r <= ST_MS;
              end
            end
            OP_UPDATE: begin
              if (!seg_valid_r) begin
                state_r <= ST_RESP;
              end else begin
                dneg_r    <= now_r < seg_time_r;
                alu_req_r <= '{start: 1'b1, op: ALU_MUL, a: AW'(mdt), b: AW'(msp)};
                state_r   <= ST_ADV;
              end
            end
            OP_STOP: begin
              run_r       <= 1'b0;
              seg_valid_r <= 1'b0;
              cur_speed_r <= '0;
              phase_r     <= PH_STOP;
              state_r     <= ST_RESP;
            end
            default: state_r <= ST_RESP;
          endcase
        end

        // Slow tick step; reject a distance below it
        ST_MS: begin
          if (alu_rsp.done) begin
            s_r <= alu_rsp.prod[AW-1:0];
            if (alu_rsp.prod > PW'(adq)) begin
              status_r <= 1'b1;
              state_r  <= ST_RESP;
            end else begin
              alu_req_r <= '{start: 1'b1, op: ALU_MUL, a: AW'(ts_r), b: AW'(tk)};
              state_r   <= ST_TS;
            end
          end
        end

        // Cut the speed when one tick would cross the distance
        ST_TS: begin
          if (alu_rsp.done) begin
            if (alu_rsp.prod > PW'(adq)) begin
              alu_req_r <= '{start: 1'b1, op: ALU_DIV, a: adq_w, b: AW'(tenk)};
              state_r   <= ST_CUT;
            end else begin
              spd_r   <= (ts_r < min_speed_r) ? min_speed_r : ts_r;
              state_r <= ST_SPD;
            end
          end
        end

        ST_CUT: begin
          if (alu_rsp.done) begin
            spd_r   <= (alu_rsp.quo[SW-1:0] < min_speed_r) ? min_speed_r
                                                          : alu_rsp.quo[SW-1:0];
            state_r <= ST_SPD;
          end
        end

        ST_SPD: begin
          if (spd_r > min_speed_r) begin
            alu_req_r <= '{start: 1'b1, op: ALU_MUL, a: AW'(spd_r), b: AW'(tk)};
            state_r   <= ST_D;
          end else begin
            sw_r    <= 1'b0;
            swt_r   <= '0;
            state_r <= ST_COMMIT;
          end
        end

        // Fast tick step, then whole fast ticks and remainder
        ST_D: begin
          if (alu_rsp.done) begin
            d_r       <= alu_rsp.prod[AW-1:0];
            alu_req_r <= '{start: 1'b1, op: ALU_DIV, a: adq_w,
                           b: alu_rsp.prod[AW-1:0]};
            state_r   <= ST_K;
          end
        end

        ST_K: begin
          if (alu_rsp.done) begin
            if (alu_rsp.quo == '0) begin
              status_r <= 1'b1;
              state_r  <= ST_RESP;
            end else if (alu_rsp.rem > tolq) begin
              k_r    <= alu_rsp.quo[MA-1:0] - 1'b1;
              n_r    <= '0;
              srch_r <= alu_rsp.rem + d_r;
              if (s_r == '0) begin
                dm_r    <= d_r;
                state_r <= ST_SRCH;
              end else begin
                alu_req_r <= '{start: 1'b1, op: ALU_DIV, a: d_r, b: s_r};
                state_r   <= ST_DM;
              end
            end else begin
              sw_r    <= 1'b0;
              swt_r   <= '0;
              state_r <= ST_COMMIT;
            end
          end
        end

        ST_DM: begin
          if (alu_rsp.done) begin
            dm_r      <= alu_rsp.rem;
            alu_req_r <= '{start: 1'b1, op: ALU_DIV, a: srch_r, b: s_r};
            state_r   <= ST_R0;
          end
        end

        ST_R0: begin
          if (alu_rsp.done) begin
            srch_r  <= alu_rsp.rem;
            state_r <= ST_SRCH;
          end
        end

        // One candidate fast tick count per cycle, counting down
        ST_SRCH: begin
          if (srch_on && !srch_hit) begin
            k_r    <= k_r - 1'b1;
            n_r    <= n_r + 1'b1;
            srch_r <= srch_nxt;
          end else begin
            alu_req_r <= '{start: 1'b1, op: ALU_MUL, a: AW'(k_fin), b: AW'(tk)};
            state_r   <= ST_SWT;
          end
        end

        ST_SWT: begin
          if (alu_rsp.done) begin
            swt_r   <= swt;
            sw_r    <= 1'b1;
            state_r <= ST_COMMIT;
          end
        end

        ST_COMMIT: begin
          sw_valid_r  <= sw_r;
          sw_time_r   <= swt_r;
          seg_valid_r <= 1'b1;
          seg_time_r  <= now_r;
          seg_coord_r <= cur_coord_r;
          goal_r      <= tgt_r;
          run_r       <= 1'b1;
          phase_r     <= (spd_r > min_speed_r) ? PH_NORMAL : PH_SLOW;
          cur_speed_r <= plan_vel;
          state_r     <= ST_RESP;
        end

        // Advance position; stop on overshoot or arrival, slow at switch
        ST_ADV: begin
          if (alu_rsp.done) begin
            cur_coord_r <= pos_sat;
            if (over || near) begin
              run_r       <= 1'b0;
              seg_valid_r <= 1'b0;
              cur_speed_r <= '0;
              phase_r     <= PH_STOP;
            end else if (sw_hit) begin
              cur_speed_r <= slow_vel;
              phase_r     <= PH_SLOW;
              seg_coord_r <= pos_sat;
              seg_time_r  <= sw_time_r;
            end
            state_r <= ST_RESP;
          end
        end

        ST_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_moving_r <= run_r;
            out_phase_r  <= phase_r;
            out_pos_r    <= cur_coord_r;
            out_vel_r    <= cur_speed_r;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.moving   = out_moving_r;
  assign out_ch.phase    = out_phase_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.velocity = out_vel_r;

  a_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == (phase_r != PH_STOP)) else $error("run flag and phase disagree");

  a_run_segment: assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid_r == run_r) else $error("segment valid and run flag disagree");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_DISPATCH)
    else $error("accepted command not dispatched");

endmodule
